FILE: rtl/clnp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clnp_pkg
// Shared types and constants of the circular list node pool: beat layouts,
// operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
package clnp_pkg;

   localparam int POOL_NODES_DEF   = 64;
   localparam int PAYLOAD_BITS_DEF = 64;

   localparam int IDX_W = 6;
   localparam int CNT_W = 7;
   localparam int PAY_W = 64;

   localparam logic MODE_ADD    = 1'b0;
   localparam logic MODE_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_INACTIVE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_LINK
   } state_type;

   typedef struct packed {
      logic             mode;
      logic [IDX_W-1:0] node_index;
      logic [PAY_W-1:0] payload;
   } req_type;

   typedef struct packed {
      status_type       status;
      logic [IDX_W-1:0] node_used;
      logic [IDX_W-1:0] head_node;
      logic [IDX_W-1:0] tail_node;
      logic             list_empty;
      logic [CNT_W-1:0] active_total;
      logic [CNT_W-1:0] recycled_total;
   } rsp_type;

endpackage
`default_nettype wire

FILE: rtl/clnp_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clnp_ram
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module clnp_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 8,
   localparam int ABITS = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [ABITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [ABITS-1:0] rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: rtl/circular_list_node_pool.sv
`default_nettype none
// ----------------------------------------------------------------------------
// circular_list_node_pool
// Node pool with a circular doubly linked active list and a LIFO free stack.
//
// Command beats enter on req_data when start is high and busy is low. An add
// takes the top recycled node or the lowest never-used node and links it in
// as the new head; a remove unlinks an active node and pushes it on the
// recycled stack. Each command returns one result beat on rsp_data, marked
// by rsp_strobe for a single cycle; the receiver cannot stall it.
// Next links (with an active bit), prev links and payloads sit in three
// synchronous RAMs. A command reads its node in the accept cycle, writes the
// node in the execute cycle and, when neighbors need relinking, writes them
// in the link state that follows. An add to an empty list, a remove of the
// only node, a full add and a bad remove go back to idle after execute; other
// commands pass through the link state too, as each link RAM has a single
// write port. rsp_strobe is high in the cycle after the execute cycle and
// may coincide with the next accept.
// Reset clears the list and stack state at once; RAMs are not swept, since
// an active bit counts only for nodes below the never-used mark.
// POOL_NODES ranges from 2 to 64, the reach of the node index field.
// ----------------------------------------------------------------------------
module circular_list_node_pool
   import clnp_pkg::*;
#(
   parameter int POOL_NODES   = POOL_NODES_DEF,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   localparam int IDX_BITS = $clog2(POOL_NODES);
   localparam int NXT_BITS = IDX_BITS + 1;
   localparam logic [CNT_W-1:0] POOL_CNT = CNT_W'(POOL_NODES);
   localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

   state_type state_ff, state_in;
   req_type   req_ff;

   logic [IDX_BITS-1:0] head_ff, head_in;
   logic [IDX_BITS-1:0] tail_ff, tail_in;
   logic [IDX_BITS-1:0] rtop_ff, rtop_in;
   logic [CNT_W-1:0]    fresh_ff, fresh_in;
   logic [CNT_W-1:0]    act_cnt_ff, act_cnt_in;
   logic [CNT_W-1:0]    rec_cnt_ff, rec_cnt_in;

   logic [IDX_BITS-1:0] w2_next_addr_ff, w2_next_addr_in;
   logic [NXT_BITS-1:0] w2_next_data_ff, w2_next_data_in;
   logic                w2_prev_en_ff, w2_prev_en_in;
   logic [IDX_BITS-1:0] w2_prev_addr_ff, w2_prev_addr_in;
   logic [IDX_BITS-1:0] w2_prev_data_ff, w2_prev_data_in;

   rsp_type rsp_ff, rsp_in;
   logic    rsp_strobe_ff;

   logic [NXT_BITS-1:0] next_rd;
   logic [IDX_BITS-1:0] prev_rd;

   logic                ex_next_en, ex_prev_en, ex_pay_en, link_needed;
   logic [IDX_BITS-1:0] ex_next_addr, ex_prev_addr, ex_pay_addr;
   logic [NXT_BITS-1:0] ex_next_data;
   logic [IDX_BITS-1:0] ex_prev_data;
   logic [PAYLOAD_BITS-1:0] ex_pay_data;

   logic                next_wr_en, prev_wr_en;
   logic [IDX_BITS-1:0] next_wr_addr, prev_wr_addr;
   logic [NXT_BITS-1:0] next_wr_data;
   logic [IDX_BITS-1:0] prev_wr_data;
   logic [IDX_BITS-1:0] next_rd_addr, prev_rd_addr;

   logic accept;

   assign accept = start && !busy;

   // sequencer: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_EXEC;
         ST_EXEC: state_in = link_needed ? ST_LINK : ST_IDLE;
         ST_LINK: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer: outputs and RAM port steering
   always_comb begin
      busy         = 1'b1;
      next_wr_en   = 1'b0;
      next_wr_addr = ex_next_addr;
      next_wr_data = ex_next_data;
      prev_wr_en   = 1'b0;
      prev_wr_addr = ex_prev_addr;
      prev_wr_data = ex_prev_data;
      unique case (state_ff)
         ST_IDLE: busy = 1'b0;
         ST_EXEC: begin
            next_wr_en = ex_next_en;
            prev_wr_en = ex_prev_en;
         end
         ST_LINK: begin
            next_wr_en   = 1'b1;
            next_wr_addr = w2_next_addr_ff;
            next_wr_data = w2_next_data_ff;
            prev_wr_en   = w2_prev_en_ff;
            prev_wr_addr = w2_prev_addr_ff;
            prev_wr_data = w2_prev_data_ff;
         end
         default: busy = 1'b1;
      endcase
   end

   assign next_rd_addr = (req_data.mode == MODE_ADD) ? rtop_ff
                                                     : req_data.node_index[IDX_BITS-1:0];
   assign prev_rd_addr = req_data.node_index[IDX_BITS-1:0];

   // execute: work out the list update from the node just read
   always_comb begin
      logic                have_rec, have_fresh, was_empty, multi, is_active, now_empty;
      logic [IDX_BITS-1:0] take_node, idx, nx, pv;
      logic [CNT_W-1:0]    idx_cnt;

      have_rec   = (rec_cnt_ff != '0);
      have_fresh = (fresh_ff < POOL_CNT);
      was_empty  = (act_cnt_ff == '0);
      multi      = (act_cnt_ff > ONE_CNT);
      take_node  = have_rec ? rtop_ff : fresh_ff[IDX_BITS-1:0];
      idx        = req_ff.node_index[IDX_BITS-1:0];
      idx_cnt    = {1'b0, req_ff.node_index};
      nx         = next_rd[IDX_BITS-1:0];
      pv         = prev_rd;
      is_active  = (idx_cnt < POOL_CNT) && (idx_cnt < fresh_ff) && next_rd[IDX_BITS];

      head_in    = head_ff;
      tail_in    = tail_ff;
      rtop_in    = rtop_ff;
      fresh_in   = fresh_ff;
      act_cnt_in = act_cnt_ff;
      rec_cnt_in = rec_cnt_ff;

      ex_next_en   = 1'b0;
      ex_next_addr = take_node;
      ex_next_data = {1'b1, was_empty ? take_node : head_ff};
      ex_prev_en   = 1'b0;
      ex_prev_addr = take_node;
      ex_prev_data = was_empty ? take_node : tail_ff;
      ex_pay_en    = 1'b0;
      ex_pay_addr  = take_node;
      ex_pay_data  = req_ff.payload[PAYLOAD_BITS-1:0];
      link_needed  = 1'b0;

      w2_next_addr_in = tail_ff;
      w2_next_data_in = {1'b1, take_node};
      w2_prev_en_in   = 1'b1;
      w2_prev_addr_in = head_ff;
      w2_prev_data_in = take_node;

      rsp_in.status    = STATUS_OK;
      rsp_in.node_used = IDX_W'(take_node);

      if (req_ff.mode == MODE_ADD) begin
         if (have_rec || have_fresh) begin
            ex_next_en  = 1'b1;
            ex_prev_en  = 1'b1;
            ex_pay_en   = 1'b1;
            link_needed = !was_empty;
            head_in     = take_node;
            tail_in     = was_empty ? take_node : tail_ff;
            act_cnt_in  = act_cnt_ff + ONE_CNT;
            if (have_rec) begin
               rtop_in    = nx;
               rec_cnt_in = rec_cnt_ff - ONE_CNT;
            end else begin
               fresh_in = fresh_ff + ONE_CNT;
            end
         end else begin
            rsp_in.status    = STATUS_FULL;
            rsp_in.node_used = '0;
         end
      end else begin
         rsp_in.node_used = req_ff.node_index;
         ex_next_addr     = idx;
         ex_next_data     = {1'b0, rtop_ff};
         ex_prev_addr     = nx;
         ex_prev_data     = pv;
         ex_pay_addr      = idx;
         ex_pay_data      = '0;
         w2_next_addr_in  = pv;
         w2_next_data_in  = {1'b1, nx};
         w2_prev_en_in    = 1'b0;
         if (is_active) begin
            ex_next_en  = 1'b1;
            ex_prev_en  = multi;
            ex_pay_en   = 1'b1;
            link_needed = multi;
            if (multi && (head_ff == idx)) head_in = nx;
            if (multi && (tail_ff == idx)) tail_in = pv;
            act_cnt_in = act_cnt_ff - ONE_CNT;
            rtop_in    = idx;
            rec_cnt_in = rec_cnt_ff + ONE_CNT;
         end else begin
            rsp_in.status = STATUS_INACTIVE;
         end
      end

      now_empty             = (act_cnt_in == '0);
      rsp_in.head_node      = now_empty ? '0 : IDX_W'(head_in);
      rsp_in.tail_node      = now_empty ? '0 : IDX_W'(tail_in);
      rsp_in.list_empty     = now_empty;
      rsp_in.active_total   = act_cnt_in;
      rsp_in.recycled_total = rec_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         rtop_ff       <= '0;
         fresh_ff      <= '0;
         act_cnt_ff    <= '0;
         rec_cnt_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= (state_ff == ST_EXEC);
         if (state_ff == ST_EXEC) begin
            head_ff    <= head_in;
            tail_ff    <= tail_in;
            rtop_ff    <= rtop_in;
            fresh_ff   <= fresh_in;
            act_cnt_ff <= act_cnt_in;
            rec_cnt_ff <= rec_cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (state_ff == ST_EXEC) begin
         rsp_ff          <= rsp_in;
         w2_next_addr_ff <= w2_next_addr_in;
         w2_next_data_ff <= w2_next_data_in;
         w2_prev_en_ff   <= w2_prev_en_in;
         w2_prev_addr_ff <= w2_prev_addr_in;
         w2_prev_data_ff <= w2_prev_data_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   clnp_ram #(.DEPTH(POOL_NODES), .WIDTH(NXT_BITS)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_wr_en),
      .wr_addr (next_wr_addr),
      .wr_data (next_wr_data),
      .rd_addr (next_rd_addr),
      .rd_data (next_rd)
   );

   clnp_ram #(.DEPTH(POOL_NODES), .WIDTH(IDX_BITS)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_wr_en),
      .wr_addr (prev_wr_addr),
      .wr_data (prev_wr_data),
      .rd_addr (prev_rd_addr),
      .rd_data (prev_rd)
   );

   clnp_ram #(.DEPTH(POOL_NODES), .WIDTH(PAYLOAD_BITS)) u_payload_ram (
      .clock   (clock),
      .wr_en   (ex_pay_en && (state_ff == ST_EXEC)),
      .wr_addr (ex_pay_addr),
      .wr_data (ex_pay_data),
      .rd_addr (ex_pay_addr),
      .rd_data ()
   );

   a_node_accounting: assert property (@(posedge clock) disable iff (reset)
      (act_cnt_ff + rec_cnt_ff) == fresh_ff)
      else $error("active plus recycled count differs from nodes handed out");

   a_strobe_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == ST_EXEC))
      else $error("result beat without an execute cycle");

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_EXEC))
      else $error("accepted command did not reach execute");

   a_link_after_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LINK) |-> $past(state_ff == ST_EXEC))
      else $error("relink cycle not preceded by execute");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> (rsp_ff.list_empty == (rsp_ff.active_total == '0)))
      else $error("empty flag disagrees with active count");

endmodule
`default_nettype wire

FILE: tb/circular_list_node_pool_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_list_node_pool_tb
// Self-checking bench for the node pool. A directed table covers the edges of
// the list: removes on an empty list, adds onto an empty list, head and tail
// removes, and recycled-node reuse. Random phases then cycle through fill-heavy,
// drain-heavy and balanced traffic with random gaps, running the pool into full and
// back to empty. Every result beat is checked field by field against the table's
// typed beat or an in-bench model of the linked list and the recycled stack.
// ----------------------------------------------------------------------------
module circular_list_node_pool_tb;
   import clnp_pkg::*;

   localparam int NODES       = POOL_NODES_DEF;
   localparam int RANDOM_CMDS = 900;

   typedef struct {
      req_type cmd;
      bit      typed;
      rsp_type want;
   } dir_row_type;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   logic [IDX_W-1:0] next_link [NODES];
   logic [IDX_W-1:0] prev_link [NODES];
   logic             is_active [NODES];
   logic [IDX_W-1:0] head_idx;
   logic [IDX_W-1:0] free_top;
   logic [CNT_W-1:0] fresh_mark;
   logic [CNT_W-1:0] live_count;
   logic [CNT_W-1:0] free_count;

   rsp_type     pending_beats [$];
   dir_row_type dir_rows [$];
   int          errors;
   int          adds_done;
   int          removes_done;
   int          full_hits;
   int          inactive_hits;

   circular_list_node_pool u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #(5_000_000);
      $display("DONE: errors detected");
      $finish;
   end

   task automatic flag_mismatch(input string msg);
      errors++;
      if (errors <= 40) begin
         $display("ERROR @%0t: %s", $realtime, msg);
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) begin
         flag_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
      end
   endtask

   function automatic rsp_type beat(input status_type s, input int used, input int hd,
                                    input int tl, input bit empty, input int act,
                                    input int rec);
      rsp_type r;
      r.status         = s;
      r.node_used      = used[IDX_W-1:0];
      r.head_node      = hd[IDX_W-1:0];
      r.tail_node      = tl[IDX_W-1:0];
      r.list_empty     = empty;
      r.active_total   = act[CNT_W-1:0];
      r.recycled_total = rec[CNT_W-1:0];
      return r;
   endfunction

   // Apply one command to the pool model and return the beat it produces.
   function automatic rsp_type pool_apply(input req_type cmd);
      rsp_type          r;
      status_type       st;
      logic [IDX_W-1:0] n;
      logic [IDX_W-1:0] p;
      logic [IDX_W-1:0] x;
      logic [IDX_W-1:0] tl;
      st = STATUS_OK;
      n  = '0;
      if (cmd.mode == MODE_ADD) begin
         if (free_count != 0) begin
            n          = free_top;
            free_top   = next_link[n];
            free_count = free_count - 1'b1;
         end else if (fresh_mark < NODES) begin
            n          = fresh_mark[IDX_W-1:0];
            fresh_mark = fresh_mark + 1'b1;
         end else begin
            st = STATUS_FULL;
         end
         if (st == STATUS_OK) begin
            if (live_count == 0) begin
               next_link[n] = n;
               prev_link[n] = n;
            end else begin
               tl                  = prev_link[head_idx];
               prev_link[n]        = tl;
               next_link[n]        = head_idx;
               next_link[tl]       = n;
               prev_link[head_idx] = n;
            end
            head_idx     = n;
            is_active[n] = 1'b1;
            live_count   = live_count + 1'b1;
            adds_done++;
         end else begin
            full_hits++;
         end
      end else begin
         n = cmd.node_index;
         if (!is_active[n]) begin
            st = STATUS_INACTIVE;
            inactive_hits++;
         end else begin
            if (live_count > 1) begin
               p            = prev_link[n];
               x            = next_link[n];
               next_link[p] = x;
               prev_link[x] = p;
               if (head_idx == n) begin
                  head_idx = x;
               end
            end
            live_count   = live_count - 1'b1;
            is_active[n] = 1'b0;
            next_link[n] = free_top;
            free_top     = n;
            free_count   = free_count + 1'b1;
            removes_done++;
         end
      end
      r.status         = st;
      r.node_used      = n;
      r.list_empty     = (live_count == 0);
      r.head_node      = (live_count == 0) ? '0 : head_idx;
      r.tail_node      = (live_count == 0) ? '0 : prev_link[head_idx];
      r.active_total   = live_count;
      r.recycled_total = free_count;
      return r;
   endfunction

   function automatic req_type pick_command(input int add_pct);
      req_type          c;
      logic [IDX_W-1:0] s;
      bit               found;
      c.payload    = {$urandom, $urandom};
      c.node_index = IDX_W'($urandom_range(NODES - 1));
      found        = 1'b0;
      if ($urandom_range(99) < add_pct) begin
         c.mode = MODE_ADD;
      end else begin
         c.mode = MODE_REMOVE;
         if ($urandom_range(9) != 0) begin
            for (int k = 0; k < NODES; k++) begin
               s = c.node_index + k[IDX_W-1:0];
               if (!found && is_active[s]) begin
                  c.node_index = s;
                  found        = 1'b1;
               end
            end
         end
      end
      return c;
   endfunction

   function automatic int pick_gap(input bit quiet);
      int k;
      k = $urandom_range(99);
      if (quiet || k < 55) begin
         return 0;
      end else if (k < 90) begin
         return $urandom_range(3, 1);
      end
      return $urandom_range(30, 4);
   endfunction

   // Hold the beat until the pool takes it; returns just after the accepting edge.
   task automatic issue(input req_type cmd, input int gap);
      bit taken;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= cmd;
      taken    = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end
   endtask

   task automatic add_row(input logic mode, input int idx, input logic [63:0] pay,
                          input bit typed, input rsp_type want);
      dir_row_type row;
      row.cmd.mode       = mode;
      row.cmd.node_index = idx[IDX_W-1:0];
      row.cmd.payload    = pay;
      row.typed          = typed;
      row.want           = want;
      dir_rows.push_back(row);
   endtask

   always @(negedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_beats.size() == 0) begin
            flag_mismatch("result beat with nothing pending");
         end else begin
            want = pending_beats.pop_front();
            check_field("status", 64'(rsp_data.status), 64'(want.status));
            check_field("node_used", 64'(rsp_data.node_used), 64'(want.node_used));
            check_field("head_node", 64'(rsp_data.head_node), 64'(want.head_node));
            check_field("tail_node", 64'(rsp_data.tail_node), 64'(want.tail_node));
            check_field("list_empty", 64'(rsp_data.list_empty), 64'(want.list_empty));
            check_field("active_total", 64'(rsp_data.active_total),
                        64'(want.active_total));
            check_field("recycled_total", 64'(rsp_data.recycled_total),
                        64'(want.recycled_total));
         end
      end
   end

   initial begin
      rsp_type pred;
      req_type cmd;
      int      sent;
      int      phase;
      int      len;
      int      pct;
      bit      quiet;

      errors        = 0;
      adds_done     = 0;
      removes_done  = 0;
      full_hits     = 0;
      inactive_hits = 0;
      for (int i = 0; i < NODES; i++) begin
         next_link[i] = '0;
         prev_link[i] = '0;
         is_active[i] = 1'b0;
      end
      head_idx   = '0;
      free_top   = '0;
      fresh_mark = '0;
      live_count = '0;
      free_count = '0;

      add_row(MODE_REMOVE, 0, 64'h0, 1'b1, beat(STATUS_INACTIVE, 0, 0, 0, 1'b1, 0, 0));
      add_row(MODE_REMOVE, 63, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
              beat(STATUS_INACTIVE, 63, 0, 0, 1'b1, 0, 0));
      add_row(MODE_ADD, 63, 64'h0, 1'b1, beat(STATUS_OK, 0, 0, 0, 1'b0, 1, 0));
      add_row(MODE_ADD, 0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
              beat(STATUS_OK, 1, 1, 0, 1'b0, 2, 0));
      add_row(MODE_ADD, 21, 64'h5555_5555_5555_5555, 1'b1,
              beat(STATUS_OK, 2, 2, 0, 1'b0, 3, 0));
      add_row(MODE_REMOVE, 0, 64'h0, 1'b0, '0);
      add_row(MODE_REMOVE, 0, 64'h0, 1'b1, beat(STATUS_INACTIVE, 0, 2, 1, 1'b0, 2, 1));
      add_row(MODE_REMOVE, 2, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0);
      add_row(MODE_ADD, 42, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0);
      add_row(MODE_REMOVE, 40, 64'h0, 1'b0, '0);
      add_row(MODE_REMOVE, 2, 64'h0, 1'b0, '0);
      add_row(MODE_REMOVE, 1, 64'h0, 1'b1, beat(STATUS_OK, 1, 0, 0, 1'b1, 0, 3));
      add_row(MODE_REMOVE, 1, 64'h0, 1'b1, beat(STATUS_INACTIVE, 1, 0, 0, 1'b1, 0, 3));
      add_row(MODE_ADD, 0, 64'h8000_0000_0000_0001, 1'b0, '0);
      add_row(MODE_ADD, 63, 64'h0000_0000_0000_0001, 1'b0, '0);
      add_row(MODE_ADD, 0, 64'h7FFF_FFFF_FFFF_FFFE, 1'b0, '0);
      add_row(MODE_ADD, 63, 64'h0123_4567_89AB_CDEF, 1'b0, '0);
      add_row(MODE_REMOVE, 3, 64'h0, 1'b0, '0);
      add_row(MODE_REMOVE, 63, 64'h0, 1'b0, '0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < dir_rows.size(); i++) begin
         issue(dir_rows[i].cmd, pick_gap(1'b0));
         pred = pool_apply(dir_rows[i].cmd);
         pending_beats.push_back(dir_rows[i].typed ? dir_rows[i].want : pred);
      end

      sent  = 0;
      phase = 0;
      while (sent < RANDOM_CMDS) begin
         len   = $urandom_range(160, 90);
         quiet = ($urandom_range(2) == 0);
         case (phase % 3)
            0: begin
               pct = 85;
            end
            1: begin
               pct = 25;
            end
            default: begin
               pct = 55;
            end
         endcase
         for (int i = 0; i < len && sent < RANDOM_CMDS; i++) begin
            cmd = pick_command(pct);
            issue(cmd, pick_gap(quiet));
            pending_beats.push_back(pool_apply(cmd));
            sent++;
         end
         phase++;
      end
      start <= 1'b0;

      while (pending_beats.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);

      $display("Covered %0d adds, %0d removes, %0d pool-full adds, %0d inactive removes.",
               adds_done, removes_done, full_hits, inactive_hits);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/clnp_pkg.sv
rtl/clnp_ram.sv
rtl/circular_list_node_pool.sv
tb/circular_list_node_pool_tb.sv
